// File: design/scbd_pkg.sv
// Types, constants and helpers shared by the straddling checkerboard decoder.
package scbd_pkg;

    localparam int unsigned CHAR_W       = 8;
    localparam int unsigned DIGIT_W      = 4;
    localparam int unsigned IDX_W        = 5;
    localparam int unsigned CFG_INDEX_W  = 3;
    localparam int unsigned CFG_DATA_W   = 64;
    localparam int unsigned ALPHA_MAX    = 28;
    localparam int unsigned CELLS_PER_ROW = 10;

    localparam logic [CHAR_W-1:0]  FILL_CHAR  = 8'h2D;  // '-'
    localparam logic [CHAR_W-1:0]  DIGIT_ZERO = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0]  DIGIT_NINE = 8'h39;  // '9'
    localparam logic [DIGIT_W-1:0] LAST_DIGIT = 4'd9;

    localparam logic [DIGIT_W-1:0] FIRST_KEY_RESET  = 4'd3;
    localparam logic [DIGIT_W-1:0] SECOND_KEY_RESET = 4'd8;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_0    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_1    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_2    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_3    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_KEY  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SECOND_KEY = 3'd5;

    // Key digit waiting for its column digit
    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_TWO   = 2'd1,
        PEND_THREE = 2'd2
    } pend_t;

    // Table row used for the lookup of a held item
    typedef enum logic [1:0] {
        ROW_ONE   = 2'd0,
        ROW_TWO   = 2'd1,
        ROW_THREE = 2'd2
    } row_t;

    typedef struct packed {
        logic [CHAR_W-1:0] in_char;
        logic              end_of_text;
    } item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              bad_pair;
    } result_t;

endpackage

// File: design/straddling_checkerboard_decoder.sv
// Straddling checkerboard decoder: input register, table lookup, result register.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------
//  item     | item_valid/item_stall | item   (in_char, end_of_text)
//  result   | result_valid/result_stall | result (out_char, bad_pair)
//  cfg      | cfg_valid/cfg_ready   | cfg_index, cfg_data (always ready)
//
// One item per cycle while item_stall is low; the result register loads from the
// input register after the cell lookup, once the result register is free.
// The pending key digit is updated at the edge the item is taken.
// Key digits make no result and do not occupy the input register.
// item_stall rises only when both the input and the result register are full
// and result_stall is high. rst_n resets all control state and config.
module straddling_checkerboard_decoder (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   item_valid,
    output logic                                   item_stall,
    input  scbd_pkg::item_t                        item,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output scbd_pkg::result_t                      result,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [scbd_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [scbd_pkg::CFG_DATA_W-1:0]        cfg_data
);

    // configuration
    logic [63:0]                          alpha0_reg, alpha1_reg, alpha2_reg;
    logic [31:0]                          alpha3_reg;
    logic [scbd_pkg::DIGIT_W-1:0]         key1_reg, key2_reg;

    // pending key digit
    scbd_pkg::pend_t                      pend_reg, pend_next;

    // input register
    logic                                 s1_valid_reg, s1_valid_next;
    logic [scbd_pkg::CHAR_W-1:0]          s1_char_reg;
    logic                                 s1_pass_reg;
    logic                                 s1_bad_reg;
    scbd_pkg::row_t                       s1_row_reg;

    // result register
    logic                                 result_valid_reg, result_valid_next;
    scbd_pkg::result_t                    result_reg;

    logic                                 accept;
    logic                                 out_free;
    logic                                 s1_move;
    logic                                 is_digit;
    logic [scbd_pkg::DIGIT_W-1:0]         digit;
    logic                                 has_result;
    logic                                 pass_thru;
    logic                                 bad;
    scbd_pkg::row_t                       row_sel;

    logic [223:0]                         alpha_flat;
    logic [scbd_pkg::CHAR_W-1:0]          alpha_byte [scbd_pkg::ALPHA_MAX];
    logic [scbd_pkg::ALPHA_MAX-1:0]       alpha_ok;
    logic                                 key1_in, key2_in;
    logic                                 key1_lt, key2_lt;
    logic [scbd_pkg::IDX_W-1:0]           row1_count;
    logic [scbd_pkg::IDX_W-1:0]           cell_idx;
    logic [scbd_pkg::CHAR_W-1:0]          cell_char;
    logic [scbd_pkg::DIGIT_W-1:0]         s1_digit;

    assign cfg_ready    = 1'b1;
    assign out_free     = !result_valid_reg || !result_stall;
    assign s1_move      = s1_valid_reg && out_free;
    assign item_stall   = s1_valid_reg && !out_free;
    assign accept       = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha0_reg <= '0;
            alpha1_reg <= '0;
            alpha2_reg <= '0;
            alpha3_reg <= '0;
            key1_reg   <= scbd_pkg::FIRST_KEY_RESET;
            key2_reg   <= scbd_pkg::SECOND_KEY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                scbd_pkg::REG_ALPHA_0:    alpha0_reg <= cfg_data;
                scbd_pkg::REG_ALPHA_1:    alpha1_reg <= cfg_data;
                scbd_pkg::REG_ALPHA_2:    alpha2_reg <= cfg_data;
                scbd_pkg::REG_ALPHA_3:    alpha3_reg <= cfg_data[31:0];
                scbd_pkg::REG_FIRST_KEY:  key1_reg   <= cfg_data[scbd_pkg::DIGIT_W-1:0];
                scbd_pkg::REG_SECOND_KEY: key2_reg   <= cfg_data[scbd_pkg::DIGIT_W-1:0];
                default:                  ;
            endcase
        end
    end

    // front end: classify the character and update the pending key
    always_comb
    begin
        is_digit   = (item.in_char >= scbd_pkg::DIGIT_ZERO) &&
                     (item.in_char <= scbd_pkg::DIGIT_NINE);
        digit      = item.in_char[scbd_pkg::DIGIT_W-1:0];
        has_result = 1'b1;
        pass_thru  = 1'b0;
        bad        = 1'b0;
        row_sel    = scbd_pkg::ROW_ONE;
        pend_next  = pend_reg;

        if (pend_reg != scbd_pkg::PEND_NONE)
        begin
            pend_next = scbd_pkg::PEND_NONE;
            if (is_digit)
            begin
                row_sel = (pend_reg == scbd_pkg::PEND_TWO) ? scbd_pkg::ROW_TWO
                                                           : scbd_pkg::ROW_THREE;
            end
            else
            begin
                pass_thru = 1'b1;
                bad       = 1'b1;
            end
        end
        else if (is_digit)
        begin
            if (digit == key1_reg)
            begin
                pend_next  = scbd_pkg::PEND_TWO;
                has_result = 1'b0;
            end
            else if (digit == key2_reg)
            begin
                pend_next  = scbd_pkg::PEND_THREE;
                has_result = 1'b0;
            end
        end
        else
        begin
            pass_thru = 1'b1;
        end

        if (item.end_of_text)
        begin
            pend_next = scbd_pkg::PEND_NONE;
        end

        if (accept)
        begin
            s1_valid_next = has_result;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg     <= scbd_pkg::PEND_NONE;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                pend_reg <= pend_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && has_result)
        begin
            s1_char_reg <= item.in_char;
            s1_pass_reg <= pass_thru;
            s1_bad_reg  <= bad;
            s1_row_reg  <= row_sel;
        end
    end

    // cell lookup
    assign alpha_flat = {alpha3_reg, alpha2_reg, alpha1_reg, alpha0_reg};
    assign s1_digit   = s1_char_reg[scbd_pkg::DIGIT_W-1:0];

    always_comb
    begin
        for (int i = 0; i < scbd_pkg::ALPHA_MAX; i++)
        begin
            alpha_byte[i] = alpha_flat[i*scbd_pkg::CHAR_W +: scbd_pkg::CHAR_W];
        end
        // symbol i is in the alphabet only if no zero byte comes at or before it
        alpha_ok[0] = |alpha_byte[0];
        for (int i = 1; i < scbd_pkg::ALPHA_MAX; i++)
        begin
            alpha_ok[i] = alpha_ok[i-1] && (|alpha_byte[i]);
        end
    end

    always_comb
    begin
        // equal keys skip one cell only
        key1_in    = key1_reg <= scbd_pkg::LAST_DIGIT;
        key2_in    = (key2_reg <= scbd_pkg::LAST_DIGIT) && (key2_reg != key1_reg);
        key1_lt    = key1_reg < s1_digit;
        key2_lt    = (key2_reg < s1_digit) && (key2_reg != key1_reg);
        row1_count = scbd_pkg::IDX_W'(scbd_pkg::CELLS_PER_ROW)
                     - {4'd0, key1_in} - {4'd0, key2_in};

        unique case (s1_row_reg)
            scbd_pkg::ROW_ONE:
                cell_idx = {1'b0, s1_digit} - {4'd0, key1_lt} - {4'd0, key2_lt};
            scbd_pkg::ROW_TWO:
                cell_idx = row1_count + {1'b0, s1_digit};
            scbd_pkg::ROW_THREE:
                cell_idx = row1_count + scbd_pkg::IDX_W'(scbd_pkg::CELLS_PER_ROW)
                           + {1'b0, s1_digit};
            default:
                cell_idx = '1;
        endcase

        if ((cell_idx < scbd_pkg::IDX_W'(scbd_pkg::ALPHA_MAX)) && alpha_ok[cell_idx])
        begin
            cell_char = alpha_byte[cell_idx];
        end
        else
        begin
            cell_char = scbd_pkg::FILL_CHAR;
        end

        result_valid_next = out_free ? s1_valid_reg : result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            result_reg.out_char <= s1_pass_reg ? s1_char_reg : cell_char;
            result_reg.bad_pair <= s1_bad_reg;
        end
    end

    // checks
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (s1_valid_reg && result_valid_reg && result_stall))
        else $error("input stalled while a register was free");

    a_held_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |=> s1_valid_reg)
        else $error("held transaction lost while stalled");

    a_eot_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.end_of_text) |=> (pend_reg == scbd_pkg::PEND_NONE))
        else $error("pending key survived end of text");

    a_bad_is_passthru: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_bad_reg) |-> s1_pass_reg)
        else $error("bad pair flagged on a table lookup");

    a_key_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (pend_reg == scbd_pkg::PEND_NONE) && !has_result) |=> !s1_valid_reg)
        else $error("key digit produced a transaction");

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the straddling checkerboard decoder.
`timescale 1ns / 100ps

module tb;

    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned REPORT_MAX = 10;

    // Indexes with no register behind them
    localparam logic [scbd_pkg::CFG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [scbd_pkg::CFG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

    // Receiver stall patterns
    localparam int unsigned STALL_NONE  = 0;
    localparam int unsigned STALL_LIGHT = 1;
    localparam int unsigned STALL_HEAVY = 2;
    localparam int unsigned STALL_RUNS  = 3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    scbd_pkg::item_t item = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    scbd_pkg::result_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [scbd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [scbd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow of the decoder's registers and key-digit state
    logic [63:0] alpha_words [4] = '{default: '0};
    logic [scbd_pkg::DIGIT_W-1:0] first_key = scbd_pkg::FIRST_KEY_RESET;
    logic [scbd_pkg::DIGIT_W-1:0] second_key = scbd_pkg::SECOND_KEY_RESET;
    scbd_pkg::pend_t row_hold = scbd_pkg::PEND_NONE;

    scbd_pkg::result_t plain_due [$];

    int unsigned fail_count = 0;
    int unsigned chars_sent = 0;
    int unsigned plain_checked = 0;
    int unsigned flagged_seen = 0;
    int unsigned reg_writes = 0;
    int unsigned settings_used = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    bit gaps_on = 1'b1;
    int unsigned stall_mode = STALL_NONE;
    int unsigned stall_left = 0;

    straddling_checkerboard_decoder uut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    // ---------------- prediction ----------------

    function automatic logic [7:0] alpha_symbol(int unsigned k);
        return alpha_words[k / 8][(k % 8) * 8 +: 8];
    endfunction

    function automatic int unsigned alpha_length();
        int unsigned n;
        n = 0;
        while (n < scbd_pkg::ALPHA_MAX && alpha_symbol(n) != 8'h00)
            n++;
        return n;
    endfunction

    function automatic bit is_key_column(int unsigned c);
        return c == first_key || c == second_key;
    endfunction

    function automatic logic [7:0] cell_symbol(scbd_pkg::row_t row, int unsigned d);
        int unsigned row1_cells;
        int unsigned idx;
        int unsigned c;
        row1_cells = 0;
        for (c = 0; c < scbd_pkg::CELLS_PER_ROW; c++)
            if (!is_key_column(c))
                row1_cells++;
        if (row == scbd_pkg::ROW_ONE)
        begin
            idx = 0;
            for (c = 0; c < d; c++)
                if (!is_key_column(c))
                    idx++;
        end
        else
        begin
            idx = row1_cells + (row == scbd_pkg::ROW_THREE ? scbd_pkg::CELLS_PER_ROW : 0) + d;
        end
        if (idx >= alpha_length())
            return scbd_pkg::FILL_CHAR;
        return alpha_symbol(idx);
    endfunction

    // Returns 1 when the character yields a plaintext byte
    function automatic bit decode_char(input scbd_pkg::item_t it,
                                       output scbd_pkg::result_t r);
        bit is_digit;
        int d;
        bit made;
        is_digit = it.in_char >= scbd_pkg::DIGIT_ZERO && it.in_char <= scbd_pkg::DIGIT_NINE;
        d = int'(it.in_char) - int'(scbd_pkg::DIGIT_ZERO);
        made = 1'b0;
        r = '0;
        if (row_hold != scbd_pkg::PEND_NONE)
        begin
            if (is_digit)
                r.out_char = cell_symbol(row_hold == scbd_pkg::PEND_TWO ? scbd_pkg::ROW_TWO
                                                                        : scbd_pkg::ROW_THREE,
                                         d);
            else
            begin
                r.out_char = it.in_char;
                r.bad_pair = 1'b1;
            end
            row_hold = scbd_pkg::PEND_NONE;
            made = 1'b1;
        end
        else if (is_digit)
        begin
            if (d == first_key)
                row_hold = scbd_pkg::PEND_TWO;
            else if (d == second_key)
                row_hold = scbd_pkg::PEND_THREE;
            else
            begin
                r.out_char = cell_symbol(scbd_pkg::ROW_ONE, d);
                made = 1'b1;
            end
        end
        else
        begin
            r.out_char = it.in_char;
            made = 1'b1;
        end
        if (it.end_of_text)
            row_hold = scbd_pkg::PEND_NONE;
        return made;
    endfunction

    // ---------------- checking ----------------

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    always @(posedge clk)
    begin : plain_check
        scbd_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (plain_due.size() == 0)
                note_failure($sformatf("unexpected result out=%02h bad=%0b",
                                       result.out_char, result.bad_pair));
            else
            begin
                want = plain_due.pop_front();
                plain_checked++;
                if (result.bad_pair)
                    flagged_seen++;
                if (result.out_char !== want.out_char || result.bad_pair !== want.bad_pair)
                    note_failure($sformatf("expected out=%02h bad=%0b, got out=%02h bad=%0b",
                                           want.out_char, want.bad_pair,
                                           result.out_char, result.bad_pair));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, plain_due.size());
            $display("FAIL");
            $finish;
        end
    end

    // Receiver stall pattern, switching to a randomly chosen style when each run ends
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(STALL_RUNS);
            stall_left = $urandom_range(300, 40);
        end
        else
            stall_left--;
        case (stall_mode)
            STALL_NONE:  result_stall <= 1'b0;
            STALL_LIGHT: result_stall <= ($urandom_range(3) == 0);
            STALL_HEAVY: result_stall <= ($urandom_range(9) < 6);
            default:     result_stall <= ((stall_left % 16) < 5);
        endcase
    end

    // ---------------- driving ----------------

    // Called at a rising edge; returns at the edge where the transaction is taken
    task automatic send_char(input logic [7:0] ch, input logic eot);
        scbd_pkg::item_t it;
        scbd_pkg::result_t r;
        it.in_char = ch;
        it.end_of_text = eot;
        if (gaps_on && burst_left == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
            burst_left = $urandom_range(24, 1);
        end
        if (burst_left > 0)
            burst_left--;
        item_valid <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (item_stall);
        chars_sent++;
        if (decode_char(it, r))
            plain_due.push_back(r);
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        while (plain_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves cfg_valid high so writes can go back to back
    task automatic write_reg(input logic [scbd_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        reg_writes++;
        case (idx)
            scbd_pkg::REG_ALPHA_0:    alpha_words[0] = data;
            scbd_pkg::REG_ALPHA_1:    alpha_words[1] = data;
            scbd_pkg::REG_ALPHA_2:    alpha_words[2] = data;
            scbd_pkg::REG_ALPHA_3:    alpha_words[3] = {32'h0, data[31:0]};
            scbd_pkg::REG_FIRST_KEY:  first_key = data[scbd_pkg::DIGIT_W-1:0];
            scbd_pkg::REG_SECOND_KEY: second_key = data[scbd_pkg::DIGIT_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [63:0] junk_word();
        return {$urandom, $urandom};
    endfunction

    // Full table reload; unused data bits carry noise
    task automatic load_setting(input logic [3:0] k1, input logic [3:0] k2,
                                input logic [28*8-1:0] syms);
        logic [63:0] noise;
        wait_idle();
        write_reg(scbd_pkg::REG_ALPHA_0, syms[63:0]);
        write_reg(scbd_pkg::REG_ALPHA_1, syms[127:64]);
        write_reg(scbd_pkg::REG_ALPHA_2, syms[191:128]);
        noise = junk_word();
        write_reg(scbd_pkg::REG_ALPHA_3, {noise[63:32], syms[223:192]});
        noise = junk_word();
        write_reg(scbd_pkg::REG_FIRST_KEY, {noise[63:4], k1});
        noise = junk_word();
        write_reg(scbd_pkg::REG_SECOND_KEY, {noise[63:4], k2});
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [28*8-1:0] alphabet_from_text(input string s);
        logic [28*8-1:0] syms;
        syms = '0;
        for (int k = 0; k < s.len() && k < scbd_pkg::ALPHA_MAX; k++)
            syms[k*8 +: 8] = s[k];
        return syms;
    endfunction

    // Nonzero symbols up to len, a terminator, then garbage that must be ignored
    function automatic logic [28*8-1:0] random_alphabet(input int unsigned len);
        logic [28*8-1:0] syms;
        for (int unsigned k = 0; k < scbd_pkg::ALPHA_MAX; k++)
        begin
            if (k < len)
                syms[k*8 +: 8] = 8'($urandom_range(255, 1));
            else if (k == len)
                syms[k*8 +: 8] = 8'h00;
            else
                syms[k*8 +: 8] = 8'($urandom_range(255));
        end
        return syms;
    endfunction

    function automatic logic [7:0] digit_char(input int unsigned d);
        return scbd_pkg::DIGIT_ZERO + 8'(d);
    endfunction

    function automatic logic [7:0] random_non_digit();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (c >= scbd_pkg::DIGIT_ZERO && c <= scbd_pkg::DIGIT_NINE);
        return c;
    endfunction

    // A key digit of the current setting, or any digit when keys exceed 9
    function automatic logic [7:0] key_char();
        logic [3:0] k;
        k = $urandom_range(1) ? first_key : second_key;
        if (k > scbd_pkg::LAST_DIGIT)
            k = 4'($urandom_range(9));
        return digit_char(k);
    endfunction

    // Mostly well-formed ciphertext with some noise; ends with end_of_text
    task automatic run_stream(input int unsigned count, input bit mid_drain);
        int unsigned sent;
        int unsigned pick;
        logic eot;
        sent = 0;
        while (sent < count)
        begin
            if (sent % 60 == 0)
                gaps_on = $urandom_range(3) != 0;
            if (mid_drain && sent >= count / 2 && sent < count / 2 + 2)
                wait_idle();
            pick = $urandom_range(99);
            eot = $urandom_range(19) == 0;
            if (pick < 40)
            begin
                send_char(digit_char($urandom_range(9)), eot);
                sent++;
            end
            else if (pick < 72)
            begin
                send_char(key_char(), 1'b0);
                send_char(digit_char($urandom_range(9)), eot);
                sent += 2;
            end
            else if (pick < 82)
            begin
                send_char(key_char(), 1'b0);
                send_char(random_non_digit(), eot);
                sent += 2;
            end
            else
            begin
                send_char(8'($urandom_range(255)), eot);
                sent++;
            end
        end
        send_char(8'($urandom_range(255)), 1'b1);
    endtask

    // ---------------- tests ----------------

    // Empty alphabet and default keys: every cell reads the fill byte
    task automatic test_reset_state();
        gaps_on = 1'b1;
        send_char(digit_char(0), 1'b0);
        send_char(digit_char(3), 1'b0);
        send_char(digit_char(5), 1'b0);
        send_char(digit_char(8), 1'b0);
        send_char(digit_char(9), 1'b0);
        send_char("Z", 1'b1);
    endtask

    task automatic test_row_one();
        load_setting(scbd_pkg::FIRST_KEY_RESET, scbd_pkg::SECOND_KEY_RESET,
                     alphabet_from_text("ABCDEFGHIJKLMNOPQRSTUVWXYZ./"));
        gaps_on = 1'b0;
        send_char(digit_char(0), 1'b0);
        send_char(digit_char(9), 1'b0);
        send_char(digit_char(1), 1'b0);
        send_char(8'h2F, 1'b0);
        send_char(8'h3A, 1'b0);
        send_char(8'hFF, 1'b1);
    endtask

    task automatic test_key_rows();
        send_char(digit_char(3), 1'b0);
        send_char(digit_char(0), 1'b0);
        send_char(digit_char(3), 1'b0);
        send_char(digit_char(9), 1'b0);
        send_char(digit_char(8), 1'b0);
        send_char(digit_char(0), 1'b0);
        send_char(digit_char(8), 1'b0);
        send_char(digit_char(9), 1'b0);
        // key digit used as the column after a key
        send_char(digit_char(3), 1'b0);
        send_char(digit_char(8), 1'b1);
    endtask

    task automatic test_broken_pairs();
        gaps_on = 1'b1;
        send_char(digit_char(3), 1'b0);
        send_char("A", 1'b0);
        send_char(digit_char(8), 1'b0);
        send_char(8'h00, 1'b0);
        // key digit on the last character is dropped
        send_char(digit_char(3), 1'b1);
        send_char(digit_char(5), 1'b1);
    endtask

    task automatic test_key_extremes();
        logic [3:0] firsts [5] = '{4'd0, 4'd9, 4'd5, 4'd12, 4'd15};
        logic [3:0] seconds [5] = '{4'd9, 4'd0, 4'd5, 4'd4, 4'd14};
        for (int k = 0; k < 5; k++)
        begin
            load_setting(firsts[k], seconds[k], random_alphabet(scbd_pkg::ALPHA_MAX));
            run_stream(150, 1'b0);
        end
    endtask

    task automatic test_alphabet_lengths();
        int unsigned lens [4] = '{0, 1, 13, 27};
        logic [3:0] k1;
        logic [3:0] k2;
        for (int k = 0; k < 4; k++)
        begin
            k1 = 4'($urandom_range(9));
            do
                k2 = 4'($urandom_range(9));
            while (k2 == k1);
            load_setting(k1, k2, random_alphabet(lens[k]));
            run_stream(150, 1'b0);
        end
    endtask

    // Spare register indexes must not disturb the table
    task automatic test_spare_indexes_and_mix();
        load_setting(4'd2, 4'd6, random_alphabet(scbd_pkg::ALPHA_MAX));
        wait_idle();
        write_reg(REG_SPARE_6, junk_word());
        write_reg(REG_SPARE_7, junk_word());
        cfg_valid <= 1'b0;
        run_stream(150, 1'b1);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_row_one();
        test_key_rows();
        test_broken_pairs();
        test_key_extremes();
        test_alphabet_lengths();
        test_spare_indexes_and_mix();
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (plain_due.size() != 0)
            note_failure($sformatf("%0d results never arrived", plain_due.size()));
        $display("Decoded %0d characters over %0d table settings; %0d plaintext bytes checked,",
                 chars_sent, settings_used, plain_checked);
        $display("  %0d of them broken pairs, %0d register writes, %0d mismatches.",
                 flagged_seen, reg_writes, fail_count);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
design/scbd_pkg.sv
design/straddling_checkerboard_decoder.sv
tb/sv/tb.sv
